### hw/rtl/point_in_polygon_crossing_macros.svh
// Assertion macros for the point-in-polygon crossing block.
// Included by the top level, which carries the concurrent checks; expects clock and reset in scope.
`ifndef POINT_IN_POLYGON_CROSSING_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_MACROS_SVH

// Same-cycle implication.
`define PIPC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PIPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pipc_pkg.sv
// Shared constants and types for the point-in-polygon crossing block.
// No dependencies.
`timescale 1ns / 1ps

package pipc_pkg;

   localparam int COORD_WIDTH_DEF = 32;

   // Stage load strobes for the edge lanes.
   typedef struct packed {
      logic ld_prep;
      logic ld_prod;
   } pipc_ctrl_type;

endpackage

### hw/rtl/pipc_front.sv
// Polygon context and input register: first vertex, previous vertex, query point.
// Depends on pipc_pkg for the default coordinate width.
`timescale 1ns / 1ps

module pipc_front #(
   parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [COORD_WIDTH-1:0] vert_x,
   input  logic signed [COORD_WIDTH-1:0] vert_y,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic                          last_vertex,
   output logic signed [COORD_WIDTH-1:0] cur_x,
   output logic signed [COORD_WIDTH-1:0] cur_y,
   output logic signed [COORD_WIDTH-1:0] old_x,
   output logic signed [COORD_WIDTH-1:0] old_y,
   output logic signed [COORD_WIDTH-1:0] first_x,
   output logic signed [COORD_WIDTH-1:0] first_y,
   output logic signed [COORD_WIDTH-1:0] query_x,
   output logic signed [COORD_WIDTH-1:0] query_y,
   output logic                          edge_en,
   output logic                          last
);

   logic                          mid_ff, mid_in;
   logic                          edge_en_ff, last_ff;
   logic signed [COORD_WIDTH-1:0] cur_x_ff, cur_y_ff, old_x_ff, old_y_ff;
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, first_x_in, first_y_in;
   logic signed [COORD_WIDTH-1:0] query_x_ff, query_y_ff, query_x_in, query_y_in;

   // Latch point and first vertex only at the start of a polygon.
   always_comb begin
      first_x_in = mid_ff ? first_x_ff : vert_x;
      first_y_in = mid_ff ? first_y_ff : vert_y;
      query_x_in = mid_ff ? query_x_ff : point_x;
      query_y_in = mid_ff ? query_y_ff : point_y;
      mid_in     = !last_vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else if (accept) begin
         mid_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         old_x_ff   <= cur_x_ff;
         old_y_ff   <= cur_y_ff;
         cur_x_ff   <= vert_x;
         cur_y_ff   <= vert_y;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         query_x_ff <= query_x_in;
         query_y_ff <= query_y_in;
         edge_en_ff <= mid_ff;
         last_ff    <= last_vertex;
      end
   end

   assign cur_x   = cur_x_ff;
   assign cur_y   = cur_y_ff;
   assign old_x   = old_x_ff;
   assign old_y   = old_y_ff;
   assign first_x = first_x_ff;
   assign first_y = first_y_ff;
   assign query_x = query_x_ff;
   assign query_y = query_y_ff;
   assign edge_en = edge_en_ff;
   assign last    = last_ff;

endmodule

### hw/rtl/pipc_edge.sv
// One edge lane: straddle test, magnitudes and signs, products, exact crossing compare.
// Depends on pipc_pkg for the stage load strobes.
`timescale 1ns / 1ps

module pipc_edge #(
   parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  pipc_pkg::pipc_ctrl_type       ctrl,
   input  logic                          edge_en,
   input  logic signed [COORD_WIDTH-1:0] xi,
   input  logic signed [COORD_WIDTH-1:0] yi,
   input  logic signed [COORD_WIDTH-1:0] xj,
   input  logic signed [COORD_WIDTH-1:0] yj,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   output logic                          toggle
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] xi_e, yi_e, xj_e, yj_e, px_e, py_e;
   logic signed [DW-1:0] dy, num, dx, dp;
   logic [DW-1:0]        a_in, b_in, mu_in, mv_in;
   logic                 act_in, lneg_in, rneg_in;

   logic [DW-1:0]        a_ff, b_ff, mu_ff, mv_ff;
   logic                 act_ff, lneg_ff, rneg_ff;

   logic [PW-1:0]        prod_l_in, prod_r_in, prod_l_ff, prod_r_ff;
   logic                 act2_ff, lneg2_ff, rneg2_ff;
   logic                 less;

   always_comb begin
      xi_e = {xi[COORD_WIDTH-1], xi};
      yi_e = {yi[COORD_WIDTH-1], yi};
      xj_e = {xj[COORD_WIDTH-1], xj};
      yj_e = {yj[COORD_WIDTH-1], yj};
      px_e = {px[COORD_WIDTH-1], px};
      py_e = {py[COORD_WIDTH-1], py};
      dy   = yj_e - yi_e;
      num  = py_e - yi_e;
      dx   = xj_e - xi_e;
      dp   = px_e - xi_e;
      a_in  = num[DW-1] ? $unsigned(-num) : $unsigned(num);
      b_in  = dy[DW-1]  ? $unsigned(-dy)  : $unsigned(dy);
      mu_in = dx[DW-1]  ? $unsigned(-dx)  : $unsigned(dx);
      mv_in = dp[DW-1]  ? $unsigned(-dp)  : $unsigned(dp);
      // Edge counts only if it straddles the ray line and one end is at or left of the point.
      act_in  = edge_en
              && (((yi < py) && (yj >= py)) || ((yj < py) && (yi >= py)))
              && ((xi <= px) || (xj <= px));
      lneg_in = dx[DW-1] && (a_in != '0);
      rneg_in = dp[DW-1] && (b_in != '0);
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_prep) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         mu_ff   <= mu_in;
         mv_ff   <= mv_in;
         act_ff  <= act_in;
         lneg_ff <= lneg_in;
         rneg_ff <= rneg_in;
      end
   end

   assign prod_l_in = PW'(a_ff) * PW'(mu_ff);
   assign prod_r_in = PW'(b_ff) * PW'(mv_ff);

   always_ff @(posedge clock) begin
      if (ctrl.ld_prod) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
         act2_ff   <= act_ff;
         lneg2_ff  <= lneg_ff;
         rneg2_ff  <= rneg_ff;
      end
   end

   // Signed compare of the two products from their magnitudes and signs.
   always_comb begin
      if (lneg2_ff != rneg2_ff) begin
         less = lneg2_ff;
      end else if (lneg2_ff) begin
         less = prod_r_ff < prod_l_ff;
      end else begin
         less = prod_l_ff < prod_r_ff;
      end
   end

   assign toggle = act2_ff && less;

endmodule

### hw/rtl/pipc_parity.sv
// Crossing parity accumulator and result register.
// Takes the toggle bits of both edge lanes; no package use.
`timescale 1ns / 1ps

module pipc_parity (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  logic last,
   input  logic tog_edge,
   input  logic tog_close,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic rsp_inside_res
);

   logic parity_ff, parity_in;
   logic valid_ff, valid_in;
   logic inside_ff;
   logic parity_next;

   always_comb begin
      parity_next = parity_ff ^ tog_edge ^ tog_close;
      parity_in   = parity_ff;
      valid_in    = valid_ff && rsp_stall;
      if (fire) begin
         // Clear at the end of a polygon so the next one starts even.
         parity_in = last ? 1'b0 : parity_next;
         if (last) begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         parity_ff <= parity_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && last) begin
         inside_ff <= parity_next;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_inside_res = inside_ff;

endmodule

### hw/rtl/point_in_polygon_crossing.sv
// Even-odd ray-crossing point-in-polygon test, top level.
// Depends on pipc_pkg, pipc_front, pipc_edge, pipc_parity and the assertion macro header.
//
//   channel   direction  ports                                           accepted when
//   request   in         req_vert_x/y, req_point_x/y, req_last_vertex    req_valid && !req_stall
//   response  out        rsp_inside_res                                  rsp_valid && !rsp_stall
//
// One vertex per cycle sustained while no waiting result stalls the pipe; each vertex runs
// through four register stages in order: input, prep, product, result.
// The edge and closing-edge lanes each hold two 33x33 multipliers in the product stage.
// Reset is synchronous; it clears the mid-polygon flag, parity, stage valids and response valid.
// Only a waiting result stalls the pipe, and only a last vertex waits behind it.
`timescale 1ns / 1ps
`include "point_in_polygon_crossing_macros.svh"

module point_in_polygon_crossing #(
   parameter int COORD_WIDTH = pipc_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_vert_x,
   input  logic signed [COORD_WIDTH-1:0] req_vert_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res
);

   pipc_pkg::pipc_ctrl_type ctrl;

   logic v1_ff, v2_ff, v3_ff, v1_in, v2_in, v3_in;
   logic last2_ff, last3_ff;
   logic last1, edge_en;
   logic fire3, ld1, accept;
   logic tog_edge, tog_close;

   logic signed [COORD_WIDTH-1:0] cur_x, cur_y, old_x, old_y;
   logic signed [COORD_WIDTH-1:0] first_x, first_y, query_x, query_y;

   // Stage handshakes: a stage loads when empty or when its item moves on.
   always_comb begin
      fire3        = v3_ff && !(last3_ff && rsp_valid && rsp_stall);
      ctrl.ld_prod = !v3_ff || fire3;
      ctrl.ld_prep = !v2_ff || ctrl.ld_prod;
      ld1          = !v1_ff || ctrl.ld_prep;
      accept       = req_valid && ld1;
      v1_in        = ld1 ? req_valid : v1_ff;
      v2_in        = ctrl.ld_prep ? v1_ff : v2_ff;
      v3_in        = ctrl.ld_prod ? v2_ff : v3_ff;
   end

   assign req_stall = !ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_prep) begin
         last2_ff <= last1;
      end
      if (ctrl.ld_prod) begin
         last3_ff <= last2_ff;
      end
   end

   pipc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .vert_x      (req_vert_x),
      .vert_y      (req_vert_y),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .last_vertex (req_last_vertex),
      .cur_x       (cur_x),
      .cur_y       (cur_y),
      .old_x       (old_x),
      .old_y       (old_y),
      .first_x     (first_x),
      .first_y     (first_y),
      .query_x     (query_x),
      .query_y     (query_y),
      .edge_en     (edge_en),
      .last        (last1)
   );

   // Edge from the current vertex back to the previous one.
   pipc_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
      .clock   (clock),
      .ctrl    (ctrl),
      .edge_en (edge_en),
      .xi      (cur_x),
      .yi      (cur_y),
      .xj      (old_x),
      .yj      (old_y),
      .px      (query_x),
      .py      (query_y),
      .toggle  (tog_edge)
   );

   // Closing edge from the first vertex to the current one, tested on the last vertex only.
   pipc_edge #(.COORD_WIDTH(COORD_WIDTH)) u_close (
      .clock   (clock),
      .ctrl    (ctrl),
      .edge_en (last1),
      .xi      (first_x),
      .yi      (first_y),
      .xj      (cur_x),
      .yj      (cur_y),
      .px      (query_x),
      .py      (query_y),
      .toggle  (tog_close)
   );

   pipc_parity u_parity (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire3),
      .last           (last3_ff),
      .tog_edge       (tog_edge),
      .tog_close      (tog_close),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_inside_res (rsp_inside_res)
   );

   `PIPC_ASSERT_NOW(a_stall_needs_item, !v1_ff, !req_stall, "request stalled with empty input stage")
   `PIPC_ASSERT_NOW(a_mid_drains, v3_ff && !last3_ff, fire3, "non-final vertex held at the end stage")
   `PIPC_ASSERT_NEXT(a_result_out, fire3 && last3_ff, rsp_valid, "final vertex gave no response")
   `PIPC_ASSERT_NOW(a_result_source, $rose(rsp_valid), $past(fire3 && last3_ff), "response without a final vertex")

endmodule
